[rtl/hrfp_pkg.sv]
package hrfp_pkg;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADHEX = 2'd2,
    ST_BADSUM = 2'd3
  } status_e;

  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_F     = 8'h46;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;

  localparam int unsigned SeenW  = 7;
  localparam int unsigned CountW = 6;

  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        byte_value;
    logic              frame_done;
    status_e           status;
    logic [CountW-1:0] byte_count;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t hex_digit(logic [7:0] c);
    digit_t d;
    logic [7:0] diff;
    d = '0;
    diff = '0;
    if (c inside {[CHR_0:CHR_9]}) begin
      diff = c - CHR_0;
      d.ok = 1'b1;
      d.value = diff[3:0];
    end else if (c inside {[CHR_A:CHR_F]}) begin
      diff = c - CHR_A + 8'd10;
      d.ok = 1'b1;
      d.value = diff[3:0];
    end
    return d;
  endfunction

  function automatic logic [CountW-1:0] sat_count(logic [SeenW-1:0] seen);
    logic [SeenW-1:0] m;
    m = '0;
    if (seen != '0) begin
      m = seen - 1'b1;
    end
    if (m > SeenW'(2**CountW - 1)) begin
      return '1;
    end
    return m[CountW-1:0];
  endfunction

endpackage

[rtl/hrfp_core.sv]
module hrfp_core import hrfp_pkg::*; #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] character_i,
  output result_t    res_o
);

  localparam logic [SeenW-1:0] MaxBytes = SeenW'(MAX_BYTES);

  phase_e           phase_q, phase_d;
  logic [3:0]       high_q, high_d;
  logic [7:0]       sum_q, sum_d;
  logic [SeenW-1:0] seen_q, seen_d;

  digit_t           dig;
  logic             eol;
  logic [7:0]       byte_w;
  logic [7:0]       sum_inc;
  logic [SeenW-1:0] seen_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      high_q  <= '0;
      sum_q   <= '0;
      seen_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      high_q  <= high_d;
      sum_q   <= sum_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    dig      = hex_digit(character_i);
    eol      = (character_i == CHR_CR) || (character_i == CHR_LF);
    byte_w   = {high_q, dig.value};
    sum_inc  = sum_q + byte_w;
    seen_inc = seen_q + 1'b1;

    phase_d = phase_q;
    high_d  = high_q;
    sum_d   = sum_q;
    seen_d  = seen_q;
    res_o   = '0;

    case (phase_q)
      PH_HIGH: begin
        if (eol) begin
          res_o.frame_done = 1'b1;
          phase_d = PH_WAIT;
          if (seen_q == '0) begin
            res_o.status = ST_EMPTY;
          end else begin
            res_o.status     = (sum_q == '0) ? ST_OK : ST_BADSUM;
            res_o.byte_count = sat_count(seen_q);
          end
        end else if (dig.ok) begin
          high_d  = dig.value;
          phase_d = PH_LOW;
        end else begin
          res_o.frame_done = 1'b1;
          res_o.status     = ST_BADHEX;
          phase_d = PH_WAIT;
        end
      end
      PH_LOW: begin
        if (dig.ok) begin
          res_o.byte_valid = 1'b1;
          res_o.byte_value = byte_w;
          sum_d   = sum_inc;
          seen_d  = seen_inc;
          phase_d = PH_HIGH;
          if (seen_inc >= MaxBytes) begin
            res_o.frame_done = 1'b1;
            res_o.status     = (sum_inc == '0) ? ST_OK : ST_BADSUM;
            res_o.byte_count = sat_count(seen_inc);
            phase_d = PH_WAIT;
          end
        end else begin
          res_o.frame_done = 1'b1;
          res_o.status     = ST_BADHEX;
          phase_d = PH_WAIT;
        end
      end
      default: begin
        phase_d = PH_WAIT;
        if (character_i == CHR_COLON) begin
          sum_d   = '0;
          seen_d  = '0;
          high_d  = '0;
          phase_d = PH_HIGH;
        end else if (!eol) begin
          res_o.frame_done = 1'b1;
          res_o.status     = ST_EMPTY;
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  a_byte_from_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.byte_valid |-> phase_q == PH_LOW)
    else $error("byte emitted outside low digit phase");

  a_done_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.frame_done |=> phase_q == PH_WAIT)
    else $error("frame end did not return to wait");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= MaxBytes)
    else $error("byte count beyond limit");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_WAIT && character_i == CHR_COLON
    |=> seen_q == '0 && sum_q == '0 && phase_q == PH_HIGH)
    else $error("start mark did not open a clean frame");
`endif

endmodule

[rtl/hex_record_frame_parser.sv]
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | character_i
// out     | out_valid_o| out_stall_i | byte_valid_o byte_value_o frame_done_o status_o
//         |            |             | byte_count_o
// One beat in gives exactly one beat out; a beat is accepted every cycle while in_stall_o is low.
// The parser state and the output register both update on the accepting edge.
// in_stall_o is high only while the output register is full and stalled.
// Reset clears the output valid and returns the parser to waiting for a start mark.
module hex_record_frame_parser import hrfp_pkg::*; #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        character_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              byte_valid_o,
  output logic [7:0]        byte_value_o,
  output logic              frame_done_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] byte_count_o
);

  logic    accept;
  logic    out_valid_q, out_valid_d;
  result_t res;
  result_t res_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  hrfp_core #(
    .MAX_BYTES(MAX_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .character_i(character_i),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = res_q.byte_valid;
  assign byte_value_o = res_q.byte_value;
  assign frame_done_o = res_q.frame_done;
  assign status_o     = res_q.status;
  assign byte_count_o = res_q.byte_count;

endmodule
